// ===== sv/fbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame buffer recycler package
// Shared constants, result codes and sequencer state type.
// ----------------------------------------------------------------------------
package fbr_pkg;

  localparam int CACHE_DEPTH     = 64;
  localparam int CACHE_AW        = 6;
  localparam int DEF_NUM_BUFFERS = 64;
  localparam int ENTRY_W         = 38;

  localparam logic [2:0] RC_HIT   = 3'd0;
  localparam logic [2:0] RC_FRESH = 3'd1;
  localparam logic [2:0] RC_NONE  = 3'd2;
  localparam logic [2:0] RC_FREED = 3'd3;
  localparam logic [2:0] RC_FULL  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FLUSH_RD,
    ST_FLUSH_WR,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_POOL_INIT,
    ST_DONE
  } state_t;

endpackage

// ===== sv/frame_buffer_recycler_core.sv =====
// A free shows its result in the cycle after acceptance. An allocate searches the
// cache from slot 0; a hit at slot k shifts each later entry down one slot.
// A miss returns every cached id to the pool, then pops a fresh id if one is left.
// One request at a time; the core goes back to idle once each result is taken.
// Reset (synchronous) starts a pool fill that writes id i into stack
// slot i; no request is taken until it finishes.
// ----------------------------------------------------------------------------
// Frame buffer recycler core
// Buffer id pool with an ordered reuse cache keyed on width and height.
// ----------------------------------------------------------------------------
module frame_buffer_recycler_core
  import fbr_pkg::*;
#(
  parameter int NUM_BUFFERS = DEF_NUM_BUFFERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] width,
  input  logic [15:0] height,
  input  logic [5:0]  buffer_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  granted_id,
  output logic [2:0]  result_code,
  output logic [6:0]  cached_count,
  output logic [6:0]  pool_free_count
);

  localparam int PAW = $clog2(NUM_BUFFERS);
  localparam int TCW = $clog2(NUM_BUFFERS + 1);

  state_t state, state_next;

  logic [6:0]     fill;
  logic [TCW-1:0] taken;
  logic [6:0]     idx;
  logic [15:0]    key_w, key_h;
  logic [PAW-1:0] init_idx;

  // Cache RAM port.
  logic                c_we;
  logic [CACHE_AW-1:0] c_addr;
  logic [ENTRY_W-1:0]  c_wdata, c_rdata;
  // Pool RAM port.
  logic                p_we;
  logic [PAW-1:0]      p_addr;
  logic [5:0]          p_wdata, p_rdata;

  fbr_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_DEPTH)) u_cache (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
  );
  fbr_ram #(.WIDTH(6), .DEPTH(NUM_BUFFERS)) u_pool (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
  );

  logic match;
  assign match = (c_rdata[31:16] == key_w) && (c_rdata[15:0] == key_h);

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign cached_count    = fill;
  assign pool_free_count = 7'(NUM_BUFFERS - int'(taken));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_POOL_INIT: if (int'(init_idx) == NUM_BUFFERS - 1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type || fill == 7'd0) state_next = req_type ? ST_DONE : ST_POP_RD;
          else state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD:  state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (match) state_next = (idx + 7'd1 < fill) ? ST_SHIFT_RD : ST_DONE;
        else if (idx + 7'd1 < fill) state_next = ST_SRCH_RD;
        else state_next = ST_FLUSH_RD;
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: state_next = (idx + 7'd2 < fill) ? ST_SHIFT_RD : ST_DONE;
      ST_FLUSH_RD: state_next = ST_FLUSH_WR;
      ST_FLUSH_WR: state_next = (idx + 7'd1 < fill) ? ST_FLUSH_RD : ST_POP_RD;
      ST_POP_RD:   state_next = (int'(taken) >= NUM_BUFFERS) ? ST_DONE : ST_POP_WAIT;
      ST_POP_WAIT: state_next = ST_DONE;
      ST_DONE:     if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // RAM port control.
  always_comb begin
    c_we    = 1'b0;
    c_addr  = idx[CACHE_AW-1:0];
    c_wdata = c_rdata;
    p_we    = 1'b0;
    p_addr  = taken[PAW-1:0];
    p_wdata = c_rdata[37:32];
    case (state)
      ST_POOL_INIT: begin
        p_we    = 1'b1;
        p_addr  = init_idx;
        p_wdata = 6'(init_idx);
      end
      ST_IDLE: begin
        c_we    = in_valid && req_type && fill < 7'(CACHE_DEPTH);
        c_addr  = fill[CACHE_AW-1:0];
        c_wdata = {buffer_id, width, height};
      end
      ST_SHIFT_RD: c_addr = CACHE_AW'(idx + 7'd1);
      ST_SHIFT_WR: c_we = 1'b1;
      ST_FLUSH_WR: begin
        p_we   = (taken != '0);
        p_addr = PAW'(taken - TCW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_POOL_INIT;
      fill     <= '0;
      taken    <= '0;
      init_idx <= '0;
      idx      <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_POOL_INIT: init_idx <= init_idx + PAW'(1);
        ST_IDLE: begin
          idx   <= '0;
          key_w <= width;
          key_h <= height;
          granted_id <= '0;
          if (in_valid && req_type) begin
            if (fill < 7'(CACHE_DEPTH)) begin
              fill <= fill + 7'd1;
              result_code <= RC_FREED;
            end else begin
              result_code <= RC_FULL;
            end
          end
        end
        ST_SRCH_CMP: begin
          if (match) begin
            granted_id  <= c_rdata[37:32];
            result_code <= RC_HIT;
            if (idx + 7'd1 >= fill) fill <= fill - 7'd1;
          end else if (idx + 7'd1 < fill) begin
            idx <= idx + 7'd1;
          end else begin
            idx <= '0;
          end
        end
        ST_SHIFT_WR: begin
          if (idx + 7'd2 < fill) idx <= idx + 7'd1;
          else fill <= fill - 7'd1;
        end
        ST_FLUSH_WR: begin
          if (taken != '0) taken <= taken - TCW'(1);
          if (idx + 7'd1 < fill) idx <= idx + 7'd1;
          else fill <= '0;
        end
        ST_POP_RD: begin
          if (int'(taken) >= NUM_BUFFERS) result_code <= RC_NONE;
        end
        ST_POP_WAIT: begin
          granted_id  <= p_rdata;
          result_code <= RC_FRESH;
          taken       <= taken + TCW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/fbr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle (a write also reads the old word), registered read data.
// ----------------------------------------------------------------------------
module fbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/fbr_checker.sv =====
// ----------------------------------------------------------------------------
// Frame buffer recycler port checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module fbr_checker
  import fbr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] granted_id,
  input logic [2:0] result_code,
  input logic [6:0] cached_count
);

  // A result is shown only while no new request can be taken.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready)) else $error("ready while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_code))
    else $error("result dropped before taken");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_code <= RC_FULL) else $error("bad result code");

  // Free and failure results carry no id.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_code == RC_FREED || result_code == RC_FULL ||
                  result_code == RC_NONE) |-> granted_id == 6'd0)
    else $error("nonzero id on non-grant");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cached_count <= 7'(CACHE_DEPTH)) else $error("cache count");

endmodule

bind frame_buffer_recycler_core fbr_checker u_fbr_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .granted_id(granted_id),
  .result_code(result_code), .cached_count(cached_count)
);
